// ===== sv/bcdl_pkg.sv =====
// Package for the block cache tag and replacement controller.
// Holds the fixed field widths, operation, result and register codes and the tag record type.
// No dependencies.
package bcdl_pkg;

   localparam int OP_W        = 3;
   localparam int FILE_W      = 16;
   localparam int ADDR_W      = 32;
   localparam int KIND_W      = 3;
   localparam int SLOT_W      = 5;
   localparam int FREE_W      = 6;
   localparam int LEVEL_W     = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int MAX_RESULTS = 33;

   localparam logic [OP_W-1:0] OP_READ        = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE       = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD         = 3'd2;
   localparam logic [OP_W-1:0] OP_EVICT_BLOCK = 3'd3;
   localparam logic [OP_W-1:0] OP_EVICT_FILE  = 3'd4;
   localparam logic [OP_W-1:0] OP_FLUSH       = 3'd5;

   localparam logic [KIND_W-1:0] KIND_DONE          = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITTEN_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASED      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RELEASED_WB   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REFUSED       = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_START_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_LEVEL  = 2'd1;

   localparam logic [LEVEL_W-1:0] START_LEVEL_RESET = 6'd4;
   localparam logic [LEVEL_W-1:0] STOP_LEVEL_RESET  = 6'd6;

   typedef struct packed {
      logic [FILE_W-1:0] file;
      logic [ADDR_W-1:0] address;
   } tag_entry_type;

endpackage

// ===== sv/block_cache_clean_dirty_lru.sv =====
// Top level of the block cache tag and replacement controller.
// Depends on bcdl_pkg, bcdl_tag_store and bcdl_link_store.
//
// Usage. A request enters on the req_ channel (valid/stall) and carries an operation,
// a file id and a byte address. Each request yields one or more results on the rsp_
// channel; the final one of a request has rsp_last set. The block takes one request at
// a time and holds req_stall high until the final result has been placed in the output
// register. The csr_ channel writes the two release levels and is always ready; it is
// meant to be written while no request is in progress.
// Timing. Lookups walk the tag memory one slot per cycle through a single comparator;
// a hit ends the walk at its slot and a miss walks all ENTRIES slots, before any list
// work. Every result then passes the output stage, and each released or written-back
// block needs list updates. A file eviction walks both recency lists, and flush
// visits each dirty block in turn. The link memories, with one write port each, set
// the list update cost. When the receiver stalls, the result waits in the output
// register and the sequencer waits with the next one. After reset all slots are free,
// both lists are empty, the free stack holds every slot with the highest on top, and
// the levels are 4 and 6.
module block_cache_clean_dirty_lru import bcdl_pkg::*; #(
   parameter int ENTRIES     = 32,
   parameter int BLOCK_BYTES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_W-1:0]      req_op,
   input  logic [FILE_W-1:0]    req_file_id,
   input  logic [ADDR_W-1:0]    req_block_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic                 rsp_found,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [FILE_W-1:0]    rsp_out_file,
   output logic [ADDR_W-1:0]    rsp_out_address,
   output logic [FREE_W-1:0]    rsp_free_slots,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEVEL_W-1:0]   csr_data
);

   localparam int IW     = $clog2(ENTRIES);
   localparam int PW     = IW + 1;
   localparam int CW     = $clog2(ENTRIES + 1);
   localparam int CMP_W  = LEVEL_W + 2;
   localparam int CNT_W  = $clog2(MAX_RESULTS);
   localparam logic [PW-1:0]     NIL       = PW'(ENTRIES);
   localparam logic [CW-1:0]     FULL      = CW'(ENTRIES);
   localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(MAX_RESULTS - 1);
   localparam logic [ADDR_W-1:0] ADDR_MASK = ~(ADDR_W'(BLOCK_BYTES - 1));

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEARCH, ST_ADD, ST_HIT_UNLINK, ST_HIT_PUSH, ST_HARVEST,
      ST_RELEASE, ST_WALK_FETCH, ST_WALK_TEST, ST_WALK_NEXT, ST_FLUSH_CHECK,
      ST_FLUSH_MOVE, ST_EMIT
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [OP_W-1:0]     op_ff, op_in;
   logic [FILE_W-1:0]   file_ff, file_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [PW-1:0]       cur_ff, cur_in, nxt_ff, nxt_in;
   logic                phase_ff, phase_in, any_ff, any_in;
   logic [PW-1:0]       cmru_ff, cmru_in, clru_ff, clru_in;
   logic [PW-1:0]       dmru_ff, dmru_in, dlru_ff, dlru_in;
   logic [CW-1:0]       fc_ff, fc_in, low_ff, low_in;
   logic [LEVEL_W-1:0]  start_ff, start_in, stop_ff, stop_in;
   logic [ENTRIES-1:0]  valid_ff, valid_in, dirty_ff, dirty_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic [KIND_W-1:0]   res_kind_ff, res_kind_in;
   logic                res_found_ff, res_found_in, res_last_ff, res_last_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [FILE_W-1:0]   res_file_ff, res_file_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic                rsp_found_ff, rsp_found_in, rsp_last_ff, rsp_last_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [FILE_W-1:0]   rsp_file_ff, rsp_file_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [FREE_W-1:0]   rsp_free_ff, rsp_free_in;

   // Memory ports.
   logic [IW-1:0]  rd_idx, ci;
   tag_entry_type  tag_q, tag_wd, key;
   logic           tag_we, key_match, file_match;
   logic [IW-1:0]  up_q, dn_q, up_wa, up_wd, dn_wa, dn_wd;
   logic           up_we, dn_we;
   logic [IW-1:0]  stack_mem [ENTRIES];
   logic [IW-1:0]  stack_q, stack_wa, stack_wd, stack_ra;
   logic           stack_we;

   // Unlink of the current slot from the list its dirty bit names.
   logic           cur_dirty;
   logic [PW-1:0]  l_mru, l_lru, unl_up, unl_dn;
   logic [PW-1:0]  clru_after, dlru_after;
   logic [CW-1:0]  fc_up, fc_dn, pop_pos;
   logic [IW-1:0]  popped;
   logic           harvest_more, add_last, rel_last, out_free, suppress;

   assign ci        = cur_ff[IW-1:0];
   assign cur_dirty = dirty_ff[ci];
   assign l_mru     = cur_dirty ? dmru_ff : cmru_ff;
   assign l_lru     = cur_dirty ? dlru_ff : clru_ff;
   assign unl_up    = (cur_ff == l_mru) ? NIL : {1'b0, up_q};
   assign unl_dn    = (cur_ff == l_lru) ? NIL : {1'b0, dn_q};
   assign clru_after = (!cur_dirty && unl_dn == NIL) ? unl_up : clru_ff;
   assign dlru_after = (cur_dirty && unl_dn == NIL) ? unl_up : dlru_ff;

   assign fc_up   = (fc_ff < FULL) ? fc_ff + 1'b1 : fc_ff;
   assign fc_dn   = fc_ff - 1'b1;
   assign pop_pos = fc_dn;
   // Stack positions below the low-water mark were never written since reset.
   assign popped  = (pop_pos < low_ff) ? pop_pos[IW-1:0] : stack_q;

   assign add_last = !((CMP_W'(fc_dn) <= CMP_W'(start_ff)) &&
                       (CMP_W'(fc_dn) < CMP_W'(stop_ff)));
   assign harvest_more = (CMP_W'(fc_up) < CMP_W'(stop_ff)) &&
                         ((clru_after != NIL) || (dlru_after != NIL));
   assign rel_last = (op_ff == OP_ADD) ? !harvest_more : (op_ff == OP_EVICT_BLOCK);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign suppress = (cnt_ff >= CNT_LIMIT) && !res_last_ff;

   assign rd_idx   = (cur_in == NIL) ? '0 : cur_in[IW-1:0];
   assign key      = '{file: file_ff, address: addr_ff};
   assign stack_ra = fc_dn[IW-1:0];

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      stack_q <= stack_mem[stack_ra];
   end

   bcdl_tag_store #(.ENTRIES(ENTRIES)) u_tag (
      .clock      (clock),
      .rd_addr    (rd_idx),
      .rd_q       (tag_q),
      .wr_en      (tag_we),
      .wr_addr    (popped),
      .wr_data    (tag_wd),
      .key        (key),
      .key_match  (key_match),
      .file_match (file_match)
   );

   bcdl_link_store #(.ENTRIES(ENTRIES)) u_link (
      .clock   (clock),
      .rd_addr (rd_idx),
      .up_q    (up_q),
      .dn_q    (dn_q),
      .up_we   (up_we),
      .up_wa   (up_wa),
      .up_wd   (up_wd),
      .dn_we   (dn_we),
      .dn_wa   (dn_wa),
      .dn_wd   (dn_wd)
   );

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;
      op_in = op_ff;  file_in = file_ff;  addr_in = addr_ff;
      cur_in = cur_ff;  nxt_in = nxt_ff;  phase_in = phase_ff;  any_in = any_ff;
      cmru_in = cmru_ff;  clru_in = clru_ff;  dmru_in = dmru_ff;  dlru_in = dlru_ff;
      fc_in = fc_ff;  low_in = low_ff;  start_in = start_ff;  stop_in = stop_ff;
      valid_in = valid_ff;  dirty_in = dirty_ff;  cnt_in = cnt_ff;
      res_kind_in = res_kind_ff;  res_found_in = res_found_ff;  res_last_in = res_last_ff;
      res_slot_in = res_slot_ff;  res_file_in = res_file_ff;  res_addr_in = res_addr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in = rsp_kind_ff;  rsp_found_in = rsp_found_ff;  rsp_last_in = rsp_last_ff;
      rsp_slot_in = rsp_slot_ff;  rsp_file_in = rsp_file_ff;  rsp_addr_in = rsp_addr_ff;
      rsp_free_in = rsp_free_ff;
      tag_we = 1'b0;  tag_wd = key;
      up_we = 1'b0;  up_wa = '0;  up_wd = '0;
      dn_we = 1'b0;  dn_wa = '0;  dn_wd = '0;
      stack_we = 1'b0;  stack_wa = fc_ff[IW-1:0];  stack_wd = ci;

      if (csr_valid) begin
         case (csr_index)
            CSR_START_LEVEL: start_in = csr_data;
            CSR_STOP_LEVEL:  stop_in  = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_op;
               file_in = req_file_id;
               addr_in = req_block_address & ADDR_MASK;
               case (req_op)
                  OP_READ, OP_WRITE, OP_ADD, OP_EVICT_BLOCK: begin
                     cur_in   = '0;
                     state_in = ST_SEARCH;
                  end
                  OP_EVICT_FILE: begin
                     phase_in = 1'b0;
                     any_in   = 1'b0;
                     cur_in   = dmru_ff;
                     state_in = ST_WALK_FETCH;
                  end
                  OP_FLUSH: state_in = ST_FLUSH_CHECK;
                  default: begin
                     res_kind_in = KIND_DONE;  res_found_in = 1'b0;  res_slot_in = '0;
                     res_file_in = req_file_id;
                     res_addr_in = req_block_address & ADDR_MASK;
                     res_last_in = 1'b1;  ret_in = ST_IDLE;  state_in = ST_EMIT;
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            res_file_in = file_ff;  res_addr_in = addr_ff;  res_last_in = 1'b1;
            ret_in = ST_IDLE;
            if (valid_ff[ci] && key_match) begin
               case (op_ff)
                  OP_READ, OP_WRITE: state_in = ST_HIT_UNLINK;
                  OP_EVICT_BLOCK:    state_in = ST_RELEASE;
                  default: begin
                     res_kind_in = KIND_DONE;  res_found_in = 1'b1;
                     res_slot_in = SLOT_W'(ci);  state_in = ST_EMIT;
                  end
               endcase
            end else if (cur_ff == PW'(ENTRIES - 1)) begin
               res_found_in = 1'b0;  res_slot_in = '0;  res_kind_in = KIND_DONE;
               if (op_ff == OP_ADD && fc_ff != '0) begin
                  state_in = ST_ADD;
               end else begin
                  if (op_ff == OP_ADD) begin
                     res_kind_in = KIND_REFUSED;
                  end
                  state_in = ST_EMIT;
               end
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end

         ST_ADD: begin
            fc_in  = fc_dn;
            low_in = (fc_dn < low_ff) ? fc_dn : low_ff;
            valid_in[popped] = 1'b1;
            dirty_in[popped] = 1'b0;
            tag_we = 1'b1;
            dn_we = 1'b1;  dn_wa = popped;  dn_wd = cmru_ff[IW-1:0];
            if (cmru_ff != NIL) begin
               up_we = 1'b1;  up_wa = cmru_ff[IW-1:0];  up_wd = popped;
            end else begin
               clru_in = {1'b0, popped};
            end
            cmru_in = {1'b0, popped};
            res_kind_in = KIND_DONE;  res_found_in = 1'b1;  res_slot_in = SLOT_W'(popped);
            res_last_in = add_last;
            ret_in   = add_last ? ST_IDLE : ST_HARVEST;
            state_in = ST_EMIT;
         end

         ST_HIT_UNLINK: begin
            if (unl_up != NIL) begin
               dn_we = 1'b1;  dn_wa = unl_up[IW-1:0];  dn_wd = unl_dn[IW-1:0];
            end
            if (unl_dn != NIL) begin
               up_we = 1'b1;  up_wa = unl_dn[IW-1:0];  up_wd = unl_up[IW-1:0];
            end
            if (cur_dirty) begin
               if (unl_up == NIL) dmru_in = unl_dn;
               dlru_in = dlru_after;
            end else begin
               if (unl_up == NIL) cmru_in = unl_dn;
               clru_in = clru_after;
            end
            state_in = ST_HIT_PUSH;
         end

         ST_HIT_PUSH: begin
            dn_we = 1'b1;  dn_wa = ci;
            if (cur_dirty || op_ff == OP_WRITE) begin
               dirty_in[ci] = 1'b1;
               dn_wd = dmru_ff[IW-1:0];
               if (dmru_ff != NIL) begin
                  up_we = 1'b1;  up_wa = dmru_ff[IW-1:0];  up_wd = ci;
               end else begin
                  dlru_in = cur_ff;
               end
               dmru_in = cur_ff;
            end else begin
               dn_wd = cmru_ff[IW-1:0];
               if (cmru_ff != NIL) begin
                  up_we = 1'b1;  up_wa = cmru_ff[IW-1:0];  up_wd = ci;
               end else begin
                  clru_in = cur_ff;
               end
               cmru_in = cur_ff;
            end
            res_kind_in = KIND_DONE;  res_found_in = 1'b1;  res_slot_in = SLOT_W'(ci);
            res_last_in = 1'b1;  ret_in = ST_IDLE;  state_in = ST_EMIT;
         end

         ST_HARVEST: begin
            cur_in   = (clru_ff != NIL) ? clru_ff : dlru_ff;
            state_in = ST_RELEASE;
         end

         ST_RELEASE: begin
            if (unl_up != NIL) begin
               dn_we = 1'b1;  dn_wa = unl_up[IW-1:0];  dn_wd = unl_dn[IW-1:0];
            end
            if (unl_dn != NIL) begin
               up_we = 1'b1;  up_wa = unl_dn[IW-1:0];  up_wd = unl_up[IW-1:0];
            end
            if (cur_dirty) begin
               if (unl_up == NIL) dmru_in = unl_dn;
               dlru_in = dlru_after;
            end else begin
               if (unl_up == NIL) cmru_in = unl_dn;
               clru_in = clru_after;
            end
            valid_in[ci] = 1'b0;
            dirty_in[ci] = 1'b0;
            if (fc_ff < FULL) begin
               stack_we = 1'b1;
            end
            fc_in  = fc_up;
            any_in = 1'b1;
            res_kind_in  = cur_dirty ? KIND_RELEASED_WB : KIND_RELEASED;
            res_found_in = 1'b1;  res_slot_in = SLOT_W'(ci);
            res_file_in  = tag_q.file;  res_addr_in = tag_q.address;
            res_last_in  = rel_last;
            if (op_ff == OP_EVICT_FILE) begin
               ret_in = ST_WALK_NEXT;
            end else if (op_ff == OP_ADD && harvest_more) begin
               ret_in = ST_HARVEST;
            end else begin
               ret_in = ST_IDLE;
            end
            state_in = ST_EMIT;
         end

         ST_WALK_FETCH: begin
            if (cur_ff == NIL) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  cur_in   = cmru_ff;
               end else begin
                  res_kind_in = KIND_DONE;  res_found_in = any_ff;  res_slot_in = '0;
                  res_file_in = file_ff;  res_addr_in = '0;  res_last_in = 1'b1;
                  ret_in = ST_IDLE;  state_in = ST_EMIT;
               end
            end else begin
               state_in = ST_WALK_TEST;
            end
         end

         ST_WALK_TEST: begin
            nxt_in = (cur_ff == (phase_ff ? clru_ff : dlru_ff)) ? NIL : {1'b0, dn_q};
            if (file_match) begin
               state_in = ST_RELEASE;
            end else begin
               cur_in   = nxt_in;
               state_in = ST_WALK_FETCH;
            end
         end

         ST_WALK_NEXT: begin
            cur_in   = nxt_ff;
            state_in = ST_WALK_FETCH;
         end

         ST_FLUSH_CHECK: begin
            if (dlru_ff == NIL) begin
               res_kind_in = KIND_DONE;  res_found_in = 1'b0;  res_slot_in = '0;
               res_file_in = '0;  res_addr_in = '0;  res_last_in = 1'b1;
               ret_in = ST_IDLE;  state_in = ST_EMIT;
            end else begin
               cur_in   = dlru_ff;
               state_in = ST_FLUSH_MOVE;
            end
         end

         ST_FLUSH_MOVE: begin
            // The slot is the dirty LRU end, so only its MRU-side neighbour changes.
            dlru_in = unl_up;
            if (unl_up == NIL) dmru_in = NIL;
            dirty_in[ci] = 1'b0;
            dn_we = 1'b1;  dn_wa = ci;  dn_wd = cmru_ff[IW-1:0];
            if (cmru_ff != NIL) begin
               up_we = 1'b1;  up_wa = cmru_ff[IW-1:0];  up_wd = ci;
            end else begin
               clru_in = cur_ff;
            end
            cmru_in = cur_ff;
            res_kind_in = KIND_WRITTEN_BACK;  res_found_in = 1'b1;  res_slot_in = SLOT_W'(ci);
            res_file_in = tag_q.file;  res_addr_in = tag_q.address;  res_last_in = 1'b0;
            ret_in = ST_FLUSH_CHECK;  state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (out_free) begin
               // Past the result limit only the final result of a request is shown.
               if (!suppress) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = res_kind_ff;  rsp_found_in = res_found_ff;
                  rsp_slot_in  = res_slot_ff;  rsp_file_in  = res_file_ff;
                  rsp_addr_in  = res_addr_ff;  rsp_last_in  = res_last_ff;
                  rsp_free_in  = FREE_W'(fc_ff);
               end
               if (res_last_ff) begin
                  cnt_in = '0;
               end else if (cnt_ff < CNT_LIMIT) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               state_in = ret_ff;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;  ret_ff <= ST_IDLE;
         cmru_ff <= NIL;  clru_ff <= NIL;  dmru_ff <= NIL;  dlru_ff <= NIL;
         fc_ff <= FULL;  low_ff <= FULL;
         start_ff <= START_LEVEL_RESET;  stop_ff <= STOP_LEVEL_RESET;
         valid_ff <= '0;  dirty_ff <= '0;  cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= 1'b0;  any_ff <= 1'b0;
      end else begin
         state_ff <= state_in;  ret_ff <= ret_in;
         cmru_ff <= cmru_in;  clru_ff <= clru_in;  dmru_ff <= dmru_in;  dlru_ff <= dlru_in;
         fc_ff <= fc_in;  low_ff <= low_in;
         start_ff <= start_in;  stop_ff <= stop_in;
         valid_ff <= valid_in;  dirty_ff <= dirty_in;  cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff <= phase_in;  any_ff <= any_in;
      end
      op_ff <= op_in;  file_ff <= file_in;  addr_ff <= addr_in;
      cur_ff <= cur_in;  nxt_ff <= nxt_in;
      res_kind_ff <= res_kind_in;  res_found_ff <= res_found_in;  res_last_ff <= res_last_in;
      res_slot_ff <= res_slot_in;  res_file_ff <= res_file_in;  res_addr_ff <= res_addr_in;
      rsp_kind_ff <= rsp_kind_in;  rsp_found_ff <= rsp_found_in;  rsp_last_ff <= rsp_last_in;
      rsp_slot_ff <= rsp_slot_in;  rsp_file_ff <= rsp_file_in;  rsp_addr_ff <= rsp_addr_in;
      rsp_free_ff <= rsp_free_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_out_file    = rsp_file_ff;
   assign rsp_out_address = rsp_addr_ff;
   assign rsp_free_slots  = rsp_free_ff;
   assign rsp_last        = rsp_last_ff;

   // Every slot is either valid or on the free stack.
   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      ($countones(valid_ff) + int'(fc_ff)) == ENTRIES)
      else $error("valid slots and free count disagree");

   // The two ends of each recency list are empty together.
   a_clean_ends: assert property (@(posedge clock) disable iff (reset)
      (clru_ff == NIL) == (cmru_ff == NIL))
      else $error("clean list ends inconsistent");

   a_dirty_ends: assert property (@(posedge clock) disable iff (reset)
      (dlru_ff == NIL) == (dmru_ff == NIL))
      else $error("dirty list ends inconsistent");

   // A dirty slot is always a valid one.
   a_dirty_valid: assert property (@(posedge clock) disable iff (reset)
      (dirty_ff & ~valid_ff) == '0)
      else $error("dirty bit set on a free slot");

endmodule

// ===== sv/bcdl_tag_store.sv =====
// Tag memory of the block cache with its shared key comparator.
// Depends on bcdl_pkg for the tag record type.
module bcdl_tag_store import bcdl_pkg::*; #(
   parameter int ENTRIES = 32
) (
   input  logic                       clock,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output tag_entry_type              rd_q,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  tag_entry_type              wr_data,
   input  tag_entry_type              key,
   output logic                       key_match,
   output logic                       file_match
);

   tag_entry_type mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q <= mem[rd_addr];
   end

   // One comparator serves the search and the file walk alike.
   assign file_match = (rd_q.file == key.file);
   assign key_match  = file_match && (rd_q.address == key.address);

endmodule

// ===== sv/bcdl_link_store.sv =====
// Recency link memories: towards-MRU and towards-LRU neighbour of every slot.
// Depends on bcdl_pkg only by convention; widths follow from ENTRIES.
module bcdl_link_store import bcdl_pkg::*; #(
   parameter int ENTRIES = 32
) (
   input  logic                       clock,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [$clog2(ENTRIES)-1:0] up_q,
   output logic [$clog2(ENTRIES)-1:0] dn_q,
   input  logic                       up_we,
   input  logic [$clog2(ENTRIES)-1:0] up_wa,
   input  logic [$clog2(ENTRIES)-1:0] up_wd,
   input  logic                       dn_we,
   input  logic [$clog2(ENTRIES)-1:0] dn_wa,
   input  logic [$clog2(ENTRIES)-1:0] dn_wd
);

   localparam int IW = $clog2(ENTRIES);

   logic [IW-1:0] up_mem [ENTRIES];
   logic [IW-1:0] dn_mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (up_we) begin
         up_mem[up_wa] <= up_wd;
      end
      up_q <= up_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (dn_we) begin
         dn_mem[dn_wa] <= dn_wd;
      end
      dn_q <= dn_mem[rd_addr];
   end

endmodule

// ===== verif/block_cache_clean_dirty_lru_tb.sv =====
// Self-checking testbench for the block cache tag and replacement controller.
// Depends on bcdl_pkg and block_cache_clean_dirty_lru; holds its own model of the cache state.
module block_cache_clean_dirty_lru_tb import bcdl_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS  = 32;
   localparam int NO_SLOT    = NUM_SLOTS;  // end marker of a recency list
   localparam int LIST_CLEAN = 0;
   localparam int LIST_DIRTY = 1;
   localparam int STALL_LIMIT = 5000;      // cycles without any handshake
   localparam int HOLD_CYCLES = 300;       // long receiver hold-off
   localparam logic [ADDR_W-1:0] ALIGN_MASK = 32'hFFFF_F000;
   localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [FILE_W-1:0] file;
      logic [ADDR_W-1:0] address;
      logic [FREE_W-1:0] free_slots;
      logic              last;
   } cache_result_type;

   // One row of the directed part. Where typed is set, the single result of the
   // request is written out by hand rather than taken from the predictor.
   typedef struct {
      logic [OP_W-1:0]   op;
      logic [FILE_W-1:0] file;
      logic [ADDR_W-1:0] address;
      bit                typed;
      logic [KIND_W-1:0] kind;
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [FILE_W-1:0] out_file;
      logic [ADDR_W-1:0] out_address;
      logic [FREE_W-1:0] free_slots;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_op = OP_READ;
   logic [FILE_W-1:0]    req_file_id = '0;
   logic [ADDR_W-1:0]    req_block_address = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [KIND_W-1:0]    rsp_kind;
   logic                 rsp_found;
   logic [SLOT_W-1:0]    rsp_slot;
   logic [FILE_W-1:0]    rsp_out_file;
   logic [ADDR_W-1:0]    rsp_out_address;
   logic [FREE_W-1:0]    rsp_free_slots;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_START_LEVEL;
   logic [LEVEL_W-1:0]   csr_data = '0;

   block_cache_clean_dirty_lru i_dut (.*);

   // Model of the cache: tags, flags, the two recency lists and the free stack.
   logic [FILE_W-1:0]  tag_file [NUM_SLOTS];
   logic [ADDR_W-1:0]  tag_address [NUM_SLOTS];
   bit                 tag_valid [NUM_SLOTS];
   bit                 tag_dirty [NUM_SLOTS];
   int                 toward_mru [2][NUM_SLOTS];
   int                 toward_lru [2][NUM_SLOTS];
   int                 mru_end [2];
   int                 lru_end [2];
   int                 free_stack [NUM_SLOTS];
   int                 free_count;
   int                 start_level;
   int                 stop_level;

   cache_result_type   fresh_results[$];   // results of the request just accepted
   cache_result_type   pending_results[$]; // results still owed by the block
   int                 errors = 0;
   int                 requests_sent = 0;
   int                 results_seen = 0;
   int                 refusals_seen = 0;
   int                 releases_seen = 0;
   int                 send_idle_pct = 0;
   int                 stall_pct = 0;
   bit                 hold_pending = 0;
   int                 hold_left = 0;
   int                 quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic void model_reset();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         tag_valid[i] = 0;
         tag_dirty[i] = 0;
         free_stack[i] = i;
      end
      for (int l = 0; l < 2; l++) begin
         mru_end[l] = NO_SLOT;
         lru_end[l] = NO_SLOT;
      end
      free_count = NUM_SLOTS;
      start_level = START_LEVEL_RESET;
      stop_level = STOP_LEVEL_RESET;
   endfunction

   function automatic void list_push_mru(int l, int s);
      toward_mru[l][s] = NO_SLOT;
      toward_lru[l][s] = mru_end[l];
      if (mru_end[l] != NO_SLOT) toward_mru[l][mru_end[l]] = s;
      else lru_end[l] = s;
      mru_end[l] = s;
   endfunction

   function automatic void list_unlink(int l, int s);
      int up;
      int down;
      up = toward_mru[l][s];
      down = toward_lru[l][s];
      if (up != NO_SLOT) toward_lru[l][up] = down;
      else mru_end[l] = down;
      if (down != NO_SLOT) toward_mru[l][down] = up;
      else lru_end[l] = up;
   endfunction

   function automatic void add_result(logic [KIND_W-1:0] kind, logic found, int slot,
                                      logic [FILE_W-1:0] file, logic [ADDR_W-1:0] address);
      cache_result_type r;
      r.kind = kind;
      r.found = found;
      r.slot = slot[SLOT_W-1:0];
      r.file = file;
      r.address = address;
      r.free_slots = free_count[FREE_W-1:0];
      r.last = 1'b0;
      fresh_results.push_back(r);
   endfunction

   function automatic int find_slot(logic [FILE_W-1:0] file, logic [ADDR_W-1:0] address);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (tag_valid[i] && tag_file[i] == file && tag_address[i] == address) return i;
      return -1;
   endfunction

   function automatic void release_slot(int s);
      bit was_dirty;
      was_dirty = tag_dirty[s];
      list_unlink(was_dirty ? LIST_DIRTY : LIST_CLEAN, s);
      tag_valid[s] = 0;
      tag_dirty[s] = 0;
      if (free_count < NUM_SLOTS) begin
         free_stack[free_count] = s;
         free_count++;
      end
      add_result(was_dirty ? KIND_RELEASED_WB : KIND_RELEASED, 1'b1, s,
                 tag_file[s], tag_address[s]);
   endfunction

   // Works out every result of one request and updates the model state.
   function automatic void predict_cache(logic [OP_W-1:0] op, logic [FILE_W-1:0] file,
                                         logic [ADDR_W-1:0] raw_address);
      logic [ADDR_W-1:0] address;
      int s;
      int cur;
      int nxt;
      bit any;
      address = raw_address & ALIGN_MASK;
      any = 0;
      case (op)
         OP_READ, OP_WRITE: begin
            s = find_slot(file, address);
            if (s < 0) begin
               add_result(KIND_DONE, 1'b0, 0, file, address);
            end else begin
               list_unlink(tag_dirty[s] ? LIST_DIRTY : LIST_CLEAN, s);
               if (op == OP_WRITE) tag_dirty[s] = 1;
               list_push_mru(tag_dirty[s] ? LIST_DIRTY : LIST_CLEAN, s);
               add_result(KIND_DONE, 1'b1, s, file, address);
            end
         end
         OP_ADD: begin
            s = find_slot(file, address);
            if (s >= 0) begin
               add_result(KIND_DONE, 1'b1, s, file, address);
            end else if (free_count == 0) begin
               add_result(KIND_REFUSED, 1'b0, 0, file, address);
            end else begin
               free_count--;
               cur = free_stack[free_count];
               tag_valid[cur] = 1;
               tag_dirty[cur] = 0;
               tag_file[cur] = file;
               tag_address[cur] = address;
               list_push_mru(LIST_CLEAN, cur);
               add_result(KIND_DONE, 1'b1, cur, file, address);
               // Refill the free pool from the clean end first, then the dirty end.
               if (free_count <= start_level) begin
                  while (free_count < stop_level) begin
                     if (lru_end[LIST_CLEAN] != NO_SLOT) release_slot(lru_end[LIST_CLEAN]);
                     else if (lru_end[LIST_DIRTY] != NO_SLOT)
                        release_slot(lru_end[LIST_DIRTY]);
                     else break;
                  end
               end
            end
         end
         OP_EVICT_BLOCK: begin
            s = find_slot(file, address);
            if (s < 0) add_result(KIND_DONE, 1'b0, 0, file, address);
            else release_slot(s);
         end
         OP_EVICT_FILE: begin
            // Dirty blocks first, then clean ones, each list walked from its MRU end.
            for (int l = LIST_DIRTY; l >= LIST_CLEAN; l--) begin
               cur = mru_end[l];
               while (cur != NO_SLOT) begin
                  nxt = toward_lru[l][cur];
                  if (tag_file[cur] == file) begin
                     release_slot(cur);
                     any = 1;
                  end
                  cur = nxt;
               end
            end
            add_result(KIND_DONE, any, 0, file, '0);
         end
         OP_FLUSH: begin
            while (lru_end[LIST_DIRTY] != NO_SLOT) begin
               cur = lru_end[LIST_DIRTY];
               list_unlink(LIST_DIRTY, cur);
               tag_dirty[cur] = 0;
               list_push_mru(LIST_CLEAN, cur);
               add_result(KIND_WRITTEN_BACK, 1'b1, cur, tag_file[cur], tag_address[cur]);
            end
            add_result(KIND_DONE, 1'b0, 0, '0, '0);
         end
         default: add_result(KIND_DONE, 1'b0, 0, file, address);
      endcase
      fresh_results[$].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Offers one request, waits for it to be taken and records what it owes.
   task automatic send_request(input directed_row_type row);
      cache_result_type typed_result;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= row.op;
      req_file_id <= row.file;
      req_block_address <= row.address;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_cache(row.op, row.file, row.address);
      if (row.typed) begin
         typed_result.kind = row.kind;
         typed_result.found = row.found;
         typed_result.slot = row.slot;
         typed_result.file = row.out_file;
         typed_result.address = row.out_address;
         typed_result.free_slots = row.free_slots;
         typed_result.last = 1'b1;
         pending_results.push_back(typed_result);
      end else begin
         foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
      end
      fresh_results.delete();
      requests_sent++;
   endtask

   // Register writes happen only with the block idle, so the model level changes at once.
   // The caller drops csr_valid once its last write has been taken.
   task automatic write_level(input logic [CSR_IDX_W-1:0] index, input int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value[LEVEL_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == CSR_START_LEVEL) start_level = value;
      else stop_level = value;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off when asked for.
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   function automatic void check_field(string name, longint unsigned expected,
                                       longint unsigned actual);
      if (expected != actual) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expected, actual);
         errors++;
      end
   endfunction

   // Each result taken from the block is compared with the oldest one owed.
   always @(posedge clock) begin
      cache_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_kind == KIND_REFUSED) refusals_seen++;
         if (rsp_kind == KIND_RELEASED || rsp_kind == KIND_RELEASED_WB) releases_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d slot %0d", rsp_kind, rsp_slot);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("found", want.found, rsp_found);
            check_field("slot", want.slot, rsp_slot);
            check_field("out_file", want.file, rsp_out_file);
            check_field("out_address", want.address, rsp_out_address);
            check_field("free_slots", want.free_slots, rsp_free_slots);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // Watchdog: the run is stuck if no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic directed_row_type plain_row(logic [OP_W-1:0] op,
                                                  logic [FILE_W-1:0] file,
                                                  logic [ADDR_W-1:0] address);
      directed_row_type row;
      row = '{op, file, address, 0, KIND_DONE, 1'b0, '0, '0, '0, '0};
      return row;
   endfunction

   function automatic directed_row_type random_row(int add_pct);
      directed_row_type row;
      int pick;
      row = plain_row(OP_READ, '0, '0);
      if ($urandom_range(99) < add_pct) begin
         row.op = OP_ADD;
      end else begin
         pick = $urandom_range(9);
         case (pick)
            0, 1, 2: row.op = OP_READ;
            3, 4, 5: row.op = OP_WRITE;
            6:       row.op = OP_EVICT_BLOCK;
            7:       row.op = OP_EVICT_FILE;
            8:       row.op = OP_FLUSH;
            default: row.op = $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
         endcase
      end
      // Mostly a small pool of keys so that hits, evictions and refills happen;
      // now and then a fully random key so that every bit moves.
      row.file = ($urandom_range(9) == 0) ? FILE_W'($urandom) : FILE_W'($urandom_range(3));
      if ($urandom_range(9) == 0) row.address = $urandom;
      else row.address = {16'h0, 4'($urandom_range(15)), 12'($urandom)};
      return row;
   endfunction

   initial begin
      directed_row_type directed [];
      int phase_start [6] = '{4, 32, 0, 8, 31, 3};
      int phase_stop  [6] = '{6, 32, 0, 20, 1, 32};
      int phase_send  [6] = '{0, 45, 0, 28, 0, 28};
      int phase_stall [6] = '{0, 0, 45, 28, 45, 28};
      int phase_add   [6] = '{40, 40, 85, 45, 50, 45};
      int phase_count [6] = '{50, 50, 70, 50, 45, 45};

      model_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, starting from the state just after reset (levels 4 and 6).
      directed = '{
         // miss on an empty cache
         '{OP_READ, 16'h0000, 32'h0000_0000, 1, KIND_DONE, 1'b0, 5'd0, 16'h0000,
           32'h0000_0000, 6'd32},
         // unused operation codes are answered and otherwise ignored
         '{OP_UNUSED_6, 16'hFFFF, 32'hFFFF_FFFF, 1, KIND_DONE, 1'b0, 5'd0, 16'hFFFF,
           32'hFFFF_F000, 6'd32},
         '{OP_UNUSED_7, 16'h0001, 32'h0000_0FFF, 1, KIND_DONE, 1'b0, 5'd0, 16'h0001,
           32'h0000_0000, 6'd32},
         // first add takes the top of the free stack, the highest slot
         '{OP_ADD, 16'h0001, 32'h0000_1234, 1, KIND_DONE, 1'b1, 5'd31, 16'h0001,
           32'h0000_1000, 6'd31},
         // adding a present block changes nothing
         '{OP_ADD, 16'h0001, 32'h0000_1FFF, 1, KIND_DONE, 1'b1, 5'd31, 16'h0001,
           32'h0000_1000, 6'd31},
         '{OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, 1, KIND_DONE, 1'b1, 5'd30, 16'hFFFF,
           32'hFFFF_F000, 6'd30},
         plain_row(OP_READ, 16'h0001, 32'h0000_1000),
         plain_row(OP_WRITE, 16'h0001, 32'h0000_1ABC),
         plain_row(OP_WRITE, 16'hFFFF, 32'hFFFF_F000),
         plain_row(OP_READ, 16'hFFFF, 32'hFFFF_F001),
         plain_row(OP_FLUSH, 16'h0000, 32'h0000_0000),
         plain_row(OP_WRITE, 16'h0001, 32'h0000_1000),
         plain_row(OP_EVICT_BLOCK, 16'h0001, 32'h0000_1000),
         // evicting a block that is not there
         '{OP_EVICT_BLOCK, 16'h0002, 32'h8000_0000, 1, KIND_DONE, 1'b0, 5'd0, 16'h0002,
           32'h8000_0000, 6'd31},
         plain_row(OP_ADD, 16'hFFFF, 32'h0000_2000),
         plain_row(OP_WRITE, 16'hFFFF, 32'h0000_2000),
         plain_row(OP_EVICT_FILE, 16'hFFFF, 32'h1234_5678),
         // evicting a file with no blocks, then flushing with nothing dirty
         '{OP_EVICT_FILE, 16'h0005, 32'h0000_5000, 1, KIND_DONE, 1'b0, 5'd0, 16'h0005,
           32'h0000_0000, 6'd32},
         '{OP_FLUSH, 16'h0007, 32'h0000_7000, 1, KIND_DONE, 1'b0, 5'd0, 16'h0000,
           32'h0000_0000, 6'd32}
      };
      foreach (directed[i]) send_request(directed[i]);
      drain_results();

      // Random part: one phase per pair of release levels and per idling pattern.
      for (int p = 0; p < 6; p++) begin
         write_level(CSR_START_LEVEL, phase_start[p]);
         write_level(CSR_STOP_LEVEL, phase_stop[p]);
         csr_valid <= 1'b0;
         send_idle_pct = phase_send[p];
         stall_pct = phase_stall[p];
         // In the first phase with both sides idling the receiver also holds off for a
         // long stretch, so the block backs up and has to stall new requests.
         if (p == 3) hold_pending = 1;
         for (int n = 0; n < phase_count[p]; n++) send_request(random_row(phase_add[p]));
         drain_results();
      end

      $display("Sent %0d requests over six level settings; %0d results checked,",
               requests_sent, results_seen);
      $display("including %0d released blocks and %0d refused adds.",
               releases_seen, refusals_seen);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/bcdl_pkg.sv
sv/bcdl_tag_store.sv
sv/bcdl_link_store.sv
sv/block_cache_clean_dirty_lru.sv
verif/block_cache_clean_dirty_lru_tb.sv
